[rtl/sexpr_pkg.sv]
// Package for the S-expression tokenizer: lexer modes, character codes, result item type.
package sexpr_pkg;

  typedef enum logic [1:0] {
    MODE_DEFAULT = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_ESCAPE  = 2'd2
  } lex_mode_t;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  typedef struct packed {
    logic [7:0] tbyte;
    logic       last;
    logic       err;
    logic       rlast;
  } tok_item_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_dec_t;

  function automatic tok_item_t mk_item(logic [7:0] b, logic last, logic err);
    tok_item_t it;
    it.tbyte = b;
    it.last  = last;
    it.err   = err;
    it.rlast = 1'b0;
    return it;
  endfunction

  function automatic esc_dec_t decode_esc(logic [7:0] c);
    esc_dec_t d;
    d.ok  = 1'b1;
    d.val = c;
    case (c)
      8'h61:     d.val = 8'h07; // a
      8'h62:     d.val = 8'h08; // b
      8'h66:     d.val = 8'h0C; // f
      8'h6E:     d.val = 8'h0A; // n
      8'h72:     d.val = 8'h0D; // r
      8'h74:     d.val = 8'h09; // t
      8'h76:     d.val = 8'h0B; // v
      CH_BSLASH: d.val = CH_BSLASH;
      CH_SQUOTE: d.val = CH_SQUOTE;
      CH_DQUOTE: d.val = CH_DQUOTE;
      CH_QMARK:  d.val = CH_QMARK;
      default: begin
        d.ok  = 1'b0;
        d.val = 8'h00;
      end
    endcase
    return d;
  endfunction

endpackage

[rtl/sexpr_tokenizer.sv]
// S-expression tokenizer: one source byte in, zero to two token bytes out.
// A result is registered into the queue and reaches out_* once the entries ahead of it drain.
// Throughput: one input byte per cycle while results drain one per cycle;
// an input that yields two results can drop in_ready until the queue is back to one entry.
// A three-entry result queue decouples the sides; in_ready is high with one entry or fewer.
// Reset (synchronous, rst_n low) sets default mode, empties the held token and the queue.
module sexpr_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_token_byte,
  output logic       out_token_last,
  output logic       out_escape_error,
  output logic       out_run_last
);
  import sexpr_pkg::*;

  localparam int QDEPTH = 3;

  lex_mode_t  mode_r, mode_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;

  tok_item_t  q_r   [QDEPTH];
  tok_item_t  q_nxt [QDEPTH];
  logic [1:0] cnt_r, cnt_nxt;

  tok_item_t  item_a, item_b;
  logic [1:0] n_items;
  logic       in_xfer, pop;
  logic [1:0] cnt_p;
  esc_dec_t   esc;
  logic [7:0] str_head;

  assign in_ready  = (cnt_r <= 2'd1);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  assign out_token_byte   = q_r[0].tbyte;
  assign out_token_last   = q_r[0].last;
  assign out_escape_error = q_r[0].err;
  assign out_run_last     = q_r[0].rlast;

  assign esc      = decode_esc(in_char_byte);
  // an empty string token first gets its opening quote
  assign str_head = held_valid_r ? held_byte_r : CH_DQUOTE;

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (in_end_of_input) begin
      mode_nxt = MODE_DEFAULT;
    end else begin
      unique case (mode_r)
        MODE_STRING: begin
          if (in_char_byte == CH_DQUOTE) mode_nxt = MODE_DEFAULT;
          else if (in_char_byte == CH_BSLASH) mode_nxt = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          mode_nxt = esc.ok ? MODE_STRING : MODE_DEFAULT;
        end
        default: begin
          if (in_char_byte == CH_DQUOTE) mode_nxt = MODE_STRING;
          else mode_nxt = MODE_DEFAULT;
        end
      endcase
    end
  end

  // result items and held token update
  always_comb begin
    n_items        = 2'd0;
    item_a         = mk_item(8'h00, 1'b0, 1'b0);
    item_b         = mk_item(8'h00, 1'b0, 1'b0);
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (in_end_of_input) begin
      if (held_valid_r) begin
        item_a  = mk_item(held_byte_r, 1'b1, 1'b0);
        n_items = 2'd1;
      end
      held_byte_nxt  = 8'h00;
      held_valid_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_STRING: begin
          if (in_char_byte == CH_DQUOTE) begin
            item_a         = mk_item(str_head, 1'b0, 1'b0);
            item_b         = mk_item(CH_DQUOTE, 1'b1, 1'b0);
            n_items        = 2'd2;
            held_byte_nxt  = 8'h00;
            held_valid_nxt = 1'b0;
          end else if (in_char_byte == CH_BSLASH) begin
            held_byte_nxt  = str_head;
            held_valid_nxt = 1'b1;
          end else begin
            item_a         = mk_item(str_head, 1'b0, 1'b0);
            n_items        = 2'd1;
            held_byte_nxt  = in_char_byte;
            held_valid_nxt = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          if (esc.ok) begin
            if (held_valid_r) begin
              item_a  = mk_item(held_byte_r, 1'b0, 1'b0);
              n_items = 2'd1;
            end
            held_byte_nxt  = esc.val;
            held_valid_nxt = 1'b1;
          end else begin
            // bad escape letter: error item, open token dropped
            item_a         = mk_item(8'h00, 1'b0, 1'b1);
            n_items        = 2'd1;
            held_byte_nxt  = 8'h00;
            held_valid_nxt = 1'b0;
          end
        end
        default: begin
          if (in_char_byte == CH_DQUOTE) begin
            // enter string mode, no output
          end else if (in_char_byte == CH_SQUOTE && !held_valid_r) begin
            item_a  = mk_item(CH_SQUOTE, 1'b1, 1'b0);
            n_items = 2'd1;
          end else if (in_char_byte == CH_LPAREN || in_char_byte == CH_RPAREN) begin
            if (held_valid_r) begin
              item_a  = mk_item(held_byte_r, 1'b1, 1'b0);
              item_b  = mk_item(in_char_byte, 1'b1, 1'b0);
              n_items = 2'd2;
            end else begin
              item_a  = mk_item(in_char_byte, 1'b1, 1'b0);
              n_items = 2'd1;
            end
            held_byte_nxt  = 8'h00;
            held_valid_nxt = 1'b0;
          end else if (in_char_byte == CH_CR || in_char_byte == CH_LF ||
                       in_char_byte == CH_TAB || in_char_byte == CH_SPACE) begin
            if (held_valid_r) begin
              item_a  = mk_item(held_byte_r, 1'b1, 1'b0);
              n_items = 2'd1;
            end
            held_byte_nxt  = 8'h00;
            held_valid_nxt = 1'b0;
          end else begin
            if (held_valid_r) begin
              item_a  = mk_item(held_byte_r, 1'b0, 1'b0);
              n_items = 2'd1;
            end
            held_byte_nxt  = in_char_byte;
            held_valid_nxt = 1'b1;
          end
        end
      endcase
    end
    if (n_items == 2'd1) item_a.rlast = 1'b1;
    if (n_items == 2'd2) item_b.rlast = 1'b1;
  end

  // result queue: shift out at head, append behind the surviving entries
  always_comb begin
    cnt_p = cnt_r - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) q_nxt[i] = q_r[i + 1];
      else q_nxt[i] = q_r[i];
    end
    if (in_xfer) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (n_items != 2'd0 && 2'(i) == cnt_p) q_nxt[i] = item_a;
        if (n_items == 2'd2 && 2'(i) == cnt_p + 2'd1) q_nxt[i] = item_b;
      end
      cnt_nxt = cnt_p + n_items;
    end else begin
      cnt_nxt = cnt_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DEFAULT;
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
      cnt_r        <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_xfer) begin
        mode_r       <= mode_nxt;
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q_r[i] <= q_nxt[i];
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH))
    else $error("result queue count out of range");

  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_escape_error |-> out_token_byte == 8'h00 && !out_token_last
                                      && out_run_last)
    else $error("escape error item carries token data");

  a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> held_byte_r == 8'h00)
    else $error("held byte not cleared with empty token");

  a_eoi_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_end_of_input |=> mode_r == MODE_DEFAULT && !held_valid_r)
    else $error("end of input did not flush the token");

endmodule
